@@ rtl/core/fqc_pkg.sv @@
// fqc_pkg: shared types and codes for the ticket queue with cancel.
// No dependencies. It is used by fqc_cell and fifo_queue_with_cancel.
`timescale 1ns / 1ps

package fqc_pkg;

  // Operation codes on kind
  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_PROCESS = 2'd1,
    KIND_CANCEL  = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  localparam int unsigned IdPortBits  = 16;
  localparam int unsigned OccPortBits = 4;

  // Control sent to every cell in the same cycle
  typedef struct packed {
    logic do_add;    // write id into the cell at the tail position
    logic do_pop;    // shift the whole row one place toward the head
    logic do_cancel; // shift the cells at and behind the first match
  } cell_ctrl_t;

endpackage

@@ rtl/core/fifo_queue_with_cancel.sv @@
// fifo_queue_with_cancel: bounded ticket queue built as a row of fqc_cell
// slots, head at cell 0. Depends on fqc_pkg and fqc_cell.
`timescale 1ns / 1ps
//
//  channel   dir  handshake            beat
//  command   in   start, busy          kind_i, ticket_id_i
//  result    out  done_o (one cycle)   status_o, served_id_o, occupancy_o,
//                                      is_empty_o, is_full_o
//
// One command per cycle; busy stays low. The result beat appears on the cycle
// after the command: add, pop and cancel each finish in one pass of the cell
// row, where all cells compare in parallel and shift together.
// Reset clears the occupancy and the result strobe; slot contents are not
// cleared and are never read before being written.
// The receiver cannot stall; each result is shown for exactly one cycle.

module fifo_queue_with_cancel import fqc_pkg::*; #(
  parameter int unsigned DEPTH   = 8,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             kind_i,
  input  logic [IdPortBits-1:0]  ticket_id_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [IdPortBits-1:0]  served_id_o,
  output logic [OccPortBits-1:0] occupancy_o,
  output logic                   is_empty_o,
  output logic                   is_full_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count_q, count_d;
  logic [ID_BITS-1:0] key;
  logic [ID_BITS-1:0] data_w [DEPTH];
  logic [DEPTH:0]     hit_w;
  cell_ctrl_t         ctrl;
  logic               empty_now, full_now, found;

  logic               done_q;
  status_e            status_q, status_d;
  logic [ID_BITS-1:0] served_q, served_d;

  assign busy      = 1'b0;
  assign key       = ID_BITS'(ticket_id_i);
  assign empty_now = count_q == '0;
  assign full_now  = count_q == CW'(DEPTH);
  assign found     = hit_w[DEPTH];
  assign hit_w[0]  = 1'b0;

  // Broadcast control to the cell row
  always_comb begin
    ctrl.do_add    = start && (kind_i == KIND_ADD) && !full_now;
    ctrl.do_pop    = start && (kind_i == KIND_PROCESS) && !empty_now;
    ctrl.do_cancel = start && (kind_i == KIND_CANCEL);
  end

  // Cell row; the last cell refills from itself
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] next_data;
    if (g == DEPTH - 1) begin : g_last
      assign next_data = data_w[g];
    end else begin : g_mid
      assign next_data = data_w[g+1];
    end
    fqc_cell #(
      .IDX     (g),
      .CW      (CW),
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .id_i        (key),
      .next_data_i (next_data),
      .hit_i       (hit_w[g]),
      .hit_o       (hit_w[g+1]),
      .data_o      (data_w[g])
    );
  end

  // Occupancy update and result beat
  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    served_d = '0;
    case (kind_i)
      KIND_ADD: begin
        if (full_now) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      KIND_PROCESS: begin
        if (empty_now) begin
          status_d = ST_EMPTY;
        end else begin
          count_d  = count_q - CW'(1);
          served_d = data_w[0];
        end
      end
      KIND_CANCEL: begin
        if (empty_now) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= start;
      if (start) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (start) begin
      status_q <= status_d;
      served_q <= served_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign served_id_o = IdPortBits'(served_q);
  assign occupancy_o = OccPortBits'(count_q);
  assign is_empty_o  = count_q == '0;
  assign is_full_o   = count_q == CW'(DEPTH);

  // Occupancy never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  // A successful add grows the queue by one
  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.do_add |=> count_q == $past(count_q) + CW'(1))
    else $error("add did not grow occupancy");

  // A pop reports the old head
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.do_pop |=> served_id_o == IdPortBits'($past(data_w[0])))
    else $error("pop served wrong identifier");

  // A cancel that finds nothing leaves occupancy unchanged
  a_cancel_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.do_cancel && !found) |=> count_q == $past(count_q))
    else $error("missed cancel changed occupancy");

  // Every command yields exactly one result beat in the next cycle
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> done_o)
    else $error("missing result beat");

endmodule

@@ rtl/core/fqc_cell.sv @@
// fqc_cell: one queue slot. Holds one identifier, compares it to the key and
// takes its neighbor's value on a shift. Depends on fqc_pkg.
`timescale 1ns / 1ps

module fqc_cell import fqc_pkg::*; #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned CW      = 4,
  parameter int unsigned ID_BITS = 16
) (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic [CW-1:0]      count_i,
  input  logic [ID_BITS-1:0] id_i,
  input  logic [ID_BITS-1:0] next_data_i,
  input  logic               hit_i,
  output logic               hit_o,
  output logic [ID_BITS-1:0] data_o
);

  logic [ID_BITS-1:0] data_q, data_d;
  logic               occupied;
  logic               at_tail;
  logic               match;

  // Position of this cell against the occupancy
  assign occupied = CW'(IDX) < count_i;
  assign at_tail  = CW'(IDX) == count_i;
  assign match    = occupied && (data_q == id_i);

  // First-match chain: set once any cell at or before this one matched
  assign hit_o = hit_i | match;

  // Next value: load at tail, shift on pop, shift behind a cancel hit
  always_comb begin
    data_d = data_q;
    if (ctrl_i.do_add && at_tail) begin
      data_d = id_i;
    end else if (ctrl_i.do_pop || (ctrl_i.do_cancel && hit_o)) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
